// ===== hdl/efc_pkg.sv =====
// Shared types and constants of the envelope follower compressor.
package efc_pkg;

   // Fixed field widths of the register file and the gain path
   localparam int COEFF_W  = 16;
   localparam int THR_W    = 15;
   localparam int THR_PAD  = 24;
   localparam int GAIN_W   = 16;
   localparam int QUO_W    = 16;
   localparam int MUL_B_W  = 33;
   localparam int CSR_IDX_W = 3;

   localparam logic [GAIN_W-1:0]  UNITY_GAIN    = 16'd32768;
   localparam logic [COEFF_W-1:0] ATTACK_RESET  = 16'd1365;
   localparam logic [COEFF_W-1:0] RELEASE_RESET = 16'd14;
   localparam logic [THR_W-1:0]   THR_RESET     = 15'd9830;
   localparam logic [COEFF_W-1:0] SLOPE_RESET   = 16'd43691;
   localparam logic [COEFF_W-1:0] MAKEUP_RESET  = 16'd19661;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK  = 3'd0,
      CSR_RELEASE = 3'd1,
      CSR_THRESH  = 3'd2,
      CSR_SLOPE   = 3'd3,
      CSR_MAKEUP  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENV_MUL,
      ST_ENV_UPD,
      ST_SLOPE_MUL,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_GAIN_MUL,
      ST_OUT_MUL,
      ST_OUT_WRITE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hdl/efc_mul.sv =====
// Shared signed multiplier with a registered product.
module efc_mul
   import efc_pkg::*;
#(
   parameter int A_W = 18,
   parameter int B_W = 33
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [A_W-1:0]     a,
   input  logic signed [B_W-1:0]     b,
   output logic signed [A_W+B_W-1:0] prod
);

   logic signed [A_W+B_W-1:0] prod_ff;
   logic signed [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W+B_W)'(a) * (A_W+B_W)'(b);

   // hold the product unless the sequencer loads new operands
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/efc_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module efc_div
   import efc_pkg::*;
#(
   parameter int NUM_W = 31,
   parameter int DEN_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic [QUO_W-1:0]     quo,
   output div_status_type       status
);

   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [QUO_W-1:0]    lo_ff, lo_in;
   logic [QUO_W-1:0]    q_ff, q_in;
   logic [DEN_W:0]      trial;

   assign trial = {rem_ff, lo_ff[QUO_W-1]} - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      if (start) begin
         // quotient is known to fit QUO_W bits, so the high part is below den
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DEN_W'(num[NUM_W-1:QUO_W]);
         lo_in   = num[QUO_W-1:0];
         den_in  = den;
         q_in    = '0;
      end else if (busy_ff) begin
         if (!trial[DEN_W]) begin
            rem_in = trial[DEN_W-1:0];
         end else begin
            rem_in = {rem_ff[DEN_W-2:0], lo_ff[QUO_W-1]};
         end
         q_in   = {q_ff[QUO_W-2:0], ~trial[DEN_W]};
         lo_in  = {lo_ff[QUO_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
   end

   assign quo         = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== hdl/envelope_follower_compressor_top.sv =====
// Feed-forward peak compressor: envelope follower, gain divider and output gain.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one word: a signed sample
//   and a block-end mark. Response channel (rsp_valid / rsp_stall) returns one
//   word per request: the compressed, made-up and saturated sample, the gain
//   used (Q1.15, unity 32768), the updated envelope and the echoed mark.
//   The CSR port (csr_valid / csr_ready, index and data) sets attack, release,
//   threshold, ratio slope and makeup gain; csr_ready is always high. Write it
//   only while no word is in flight.
//   One shared multiplier carries all four products and a radix-2 divider
//   yields the 16 gain bits one per cycle; the divider runs only when the
//   envelope is above the threshold. req_stall stays high until the previous
//   result is registered, so no new word is taken before then.
//   The response register parts the two sides: a new request is taken while
//   the last response still waits on rsp_stall; a finished result waits in the
//   last sequencer step until the response register frees.
//   Reset (synchronous, active high) clears the envelope, loads the default
//   register values and empties the response register.
module envelope_follower_compressor_top
   import efc_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                        req_last_of_block,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [GAIN_W-1:0]           rsp_gain_applied,
   output logic [SAMPLE_BITS-2:0]      rsp_envelope_level,
   output logic                        rsp_last_out,
   // CSR write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [COEFF_W-1:0]          csr_data
);

   localparam int EW = SAMPLE_BITS - 1;
   localparam int AW = (SAMPLE_BITS + 1 > 18) ? SAMPLE_BITS + 1 : 18;
   localparam int PW = AW + MUL_B_W;
   localparam int NW = SAMPLE_BITS + 15;
   localparam int TW = THR_W + THR_PAD;

   localparam logic signed [PW-1:0] ENV_HALF = PW'(64'sd1 <<< 15);
   localparam logic signed [PW-1:0] OUT_HALF = PW'(64'sd1 <<< 28);
   localparam logic signed [PW-1:0] Y_MAX    = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [PW-1:0] Y_MIN    = -Y_MAX - PW'(64'sd1);
   localparam logic signed [PW-1:0] ENV_TOP  = Y_MAX;

   // ---------------------------------------------------------------
   // CSR registers
   // ---------------------------------------------------------------
   logic [COEFF_W-1:0] attack_ff, release_ff, slope_ff, makeup_ff;
   logic [THR_W-1:0]   threshold_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff    <= ATTACK_RESET;
         release_ff   <= RELEASE_RESET;
         threshold_ff <= THR_RESET;
         slope_ff     <= SLOPE_RESET;
         makeup_ff    <= MAKEUP_RESET;
      end else if (csr_valid && csr_ready) begin
         // drop writes to unused indexes
         unique case (csr_index)
            CSR_ATTACK:  attack_ff    <= csr_data;
            CSR_RELEASE: release_ff   <= csr_data;
            CSR_THRESH:  threshold_ff <= csr_data[THR_W-1:0];
            CSR_SLOPE:   slope_ff     <= csr_data;
            CSR_MAKEUP:  makeup_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Threshold on the envelope scale: the top EW bits of the padded Q0.15 value
   logic [TW-1:0] thr_wide;
   logic [EW-1:0] thr_w;

   assign thr_wide = {threshold_ff, {THR_PAD{1'b0}}};
   assign thr_w    = thr_wide[TW-1 -: EW];

   // ---------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------
   state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          last_ff;
   logic [EW-1:0]                 env_ff, env_in;
   logic [GAIN_W-1:0]             gain_ff;

   logic signed [PW-1:0]          prod;
   logic                          mul_en;
   logic signed [AW-1:0]          mul_a;
   logic signed [MUL_B_W-1:0]     mul_b;

   logic                          div_start;
   logic [QUO_W-1:0]              div_quo;
   div_status_type                div_status;
   logic [NW-1:0]                 div_num;
   logic [SAMPLE_BITS-1:0]        div_den;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic [GAIN_W-1:0]             rsp_gain_ff;
   logic [EW-1:0]                 rsp_env_ff;
   logic                          rsp_last_ff;
   logic                          out_free;

   // Rectified level, most negative sample saturates to full scale
   logic [SAMPLE_BITS-1:0] neg_x;
   logic                   x_is_min;
   logic [EW-1:0]          level;
   logic signed [EW+1:0]   diff_s;
   logic [COEFF_W-1:0]     coeff;
   logic [EW-1:0]          excess;

   assign neg_x    = -x_ff;
   assign x_is_min = x_ff[SAMPLE_BITS-1] && (x_ff[SAMPLE_BITS-2:0] == '0);
   assign level    = x_is_min ? {EW{1'b1}} :
                     (x_ff[SAMPLE_BITS-1] ? neg_x[EW-1:0] : x_ff[EW-1:0]);
   assign diff_s   = $signed({2'b00, level}) - $signed({2'b00, env_ff});
   assign coeff    = (level > env_ff) ? attack_ff : release_ff;
   assign excess   = env_ff - thr_w;

   // Envelope step: round half up, then clamp to the envelope range
   logic signed [PW-1:0] env_rnd, env_delta, env_sum;

   assign env_rnd   = prod + ENV_HALF;
   assign env_delta = env_rnd >>> 16;
   assign env_sum   = PW'($signed({1'b0, env_ff})) + env_delta;

   always_comb begin
      if (env_sum < 0) begin
         env_in = '0;
      end else if (env_sum > ENV_TOP) begin
         env_in = {EW{1'b1}};
      end else begin
         env_in = env_sum[EW-1:0];
      end
   end

   // Output rounding by 2^29 and saturation to the sample range
   logic signed [PW-1:0] out_rnd, out_w;

   assign out_rnd = prod + OUT_HALF;
   assign out_w   = out_rnd >>> 29;

   always_comb begin
      if (out_w > Y_MAX) begin
         rsp_sample_in = Y_MAX[SAMPLE_BITS-1:0];
      end else if (out_w < Y_MIN) begin
         rsp_sample_in = Y_MIN[SAMPLE_BITS-1:0];
      end else begin
         rsp_sample_in = out_w[SAMPLE_BITS-1:0];
      end
   end

   // Reduction numerator and divisor: ((env-thr)*slope + env) / (2*env)
   assign div_num = prod[NW-1:0] + NW'(env_ff);
   assign div_den = {env_ff, 1'b0};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_ENV_MUL;
         ST_ENV_MUL:   state_in = ST_ENV_UPD;
         ST_ENV_UPD:   state_in = ST_SLOPE_MUL;
         ST_SLOPE_MUL: state_in = (env_ff > thr_w) ? ST_DIV_LOAD : ST_GAIN_MUL;
         ST_DIV_LOAD:  state_in = ST_DIV_RUN;
         ST_DIV_RUN:   if (div_status.done) state_in = ST_GAIN_MUL;
         ST_GAIN_MUL:  state_in = ST_OUT_MUL;
         ST_OUT_MUL:   state_in = ST_OUT_WRITE;
         ST_OUT_WRITE: if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: multiplier operands, divider start, request stall
   always_comb begin
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_ENV_MUL: begin
            mul_en = 1'b1;
            mul_a  = AW'(diff_s);
            mul_b  = MUL_B_W'($signed({1'b0, coeff}));
         end
         ST_SLOPE_MUL: begin
            mul_en = 1'b1;
            mul_a  = AW'($signed({1'b0, excess}));
            mul_b  = MUL_B_W'($signed({1'b0, slope_ff}));
         end
         ST_DIV_LOAD: begin
            div_start = 1'b1;
         end
         ST_GAIN_MUL: begin
            mul_en = 1'b1;
            mul_a  = AW'($signed({1'b0, gain_ff}));
            mul_b  = MUL_B_W'($signed({1'b0, makeup_ff}));
         end
         ST_OUT_MUL: begin
            // gain times makeup is below 2^31, so its low 32 bits carry it all
            mul_en = 1'b1;
            mul_a  = AW'(x_ff);
            mul_b  = MUL_B_W'($signed({1'b0, prod[MUL_B_W-2:0]}));
         end
         ST_ENV_UPD, ST_DIV_RUN, ST_OUT_WRITE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         env_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ENV_UPD) begin
            env_ff <= env_in;
         end
      end
   end

   // Payload registers: capture the request, hold the gain
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         x_ff    <= req_sample_in;
         last_ff <= req_last_of_block;
      end
      if (state_ff == ST_SLOPE_MUL && !(env_ff > thr_w)) begin
         gain_ff <= UNITY_GAIN;
      end else if (state_ff == ST_DIV_RUN && div_status.done) begin
         gain_ff <= UNITY_GAIN - div_quo;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT_WRITE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT_WRITE && out_free) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_gain_ff   <= gain_ff;
         rsp_env_ff    <= env_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_gain_applied   = rsp_gain_ff;
   assign rsp_envelope_level = rsp_env_ff;
   assign rsp_last_out       = rsp_last_ff;

   // ---------------------------------------------------------------
   // Shared arithmetic units
   // ---------------------------------------------------------------
   efc_mul #(
      .A_W (AW),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   efc_div #(
      .NUM_W (NW),
      .DEN_W (SAMPLE_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quo    (div_quo),
      .status (div_status)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain_applied <= UNITY_GAIN)
      else $error("gain above unity");

   a_gain_only_above_thr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_gain_applied != UNITY_GAIN) |-> rsp_envelope_level > thr_w)
      else $error("gain reduced with envelope at or below threshold");

   a_div_in_run: assert property (@(posedge clock) disable iff (reset)
      (div_status.busy || div_status.done) |-> state_ff == ST_DIV_RUN)
      else $error("divider active outside its sequencer step");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a word is in flight");

endmodule
